// File: rtl/core/wmpa_pkg.sv
// Shared types and constants for the wrench-to-motor pulse allocator.
// Holds the fixed allocation coefficient table, register indexes and state codes.
// No dependencies.
package wmpa_pkg;

   localparam int MotorCount   = 8;
   localparam int WrenchCount  = 6;
   localparam int AxisCount    = 3;
   localparam int CoefRomBits  = 18;
   localparam int CoefIntBits  = 3;
   localparam int PulseBits    = 12;
   localparam int GainBits     = 16;
   localparam int RootGainFrac = 12;
   localparam int CsrDataBits  = 16;

   typedef enum logic [1:0] {
      CSR_PULSE_CENTER = 2'd0,
      CSR_PULSE_MIN    = 2'd1,
      CSR_PULSE_MAX    = 2'd2,
      CSR_THRUST_GAIN  = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_FORCE  = 1'b0,
      OP_TORQUE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_MAC,
      ST_NORM,
      ST_ROOT,
      ST_SCALE,
      ST_APPLY,
      ST_DONE
   } state_type;

   localparam logic [PulseBits-1:0] PulseCenterReset = 12'd1500;
   localparam logic [PulseBits-1:0] PulseMinReset    = 12'd1000;
   localparam logic [PulseBits-1:0] PulseMaxReset    = 12'd2000;
   localparam logic [GainBits-1:0]  ThrustGainReset  = 16'd65037;

   localparam logic signed [CoefRomBits-1:0] RomA = 18'sd9691;
   localparam logic signed [CoefRomBits-1:0] RomB = 18'sd2597;
   localparam logic signed [CoefRomBits-1:0] RomC = 18'sd7094;

   // rows: motors; columns: force x,y,z then torque x,y,z (Q2.15)
   localparam logic signed [CoefRomBits-1:0] ALLOC_ROM [MotorCount][WrenchCount] = '{
      '{-RomA,  RomB,  RomC,  RomB, -RomA,  RomC},
      '{ RomB,  RomA, -RomC, -RomA, -RomB, -RomC},
      '{-RomB, -RomA, -RomC,  RomA,  RomB, -RomC},
      '{ RomA, -RomB,  RomC, -RomB,  RomA,  RomC},
      '{ RomA, -RomB,  RomC,  RomB, -RomA, -RomC},
      '{-RomB, -RomA, -RomC, -RomA, -RomB,  RomC},
      '{ RomB,  RomA, -RomC,  RomA,  RomB,  RomC},
      '{-RomA,  RomB,  RomC, -RomB,  RomA, -RomC}
   };

endpackage

// File: rtl/core/wmpa_isqrt.sv
// Iterative floor integer square root, one result bit per cycle.
// Used by the allocator top level; depends on nothing else.
module wmpa_isqrt #(
   parameter int RAD_BITS = 18
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [RAD_BITS-1:0]   radicand,
   output logic                  done,
   output logic [RAD_BITS/2-1:0] root
);

   localparam int RootBits = RAD_BITS / 2;
   localparam int CntBits  = $clog2(RootBits + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CntBits-1:0]  cnt_ff;
   logic [RAD_BITS-1:0] rad_ff;
   logic [RootBits+1:0] rem_ff;
   logic [RootBits-1:0] root_ff;

   logic [RootBits+1:0] rem_sh;
   logic [RootBits+1:0] trial;
   logic                take;
   logic [RootBits+1:0] rem_in;
   logic [RootBits-1:0] root_in;

   always_comb begin
      rem_sh  = {rem_ff[RootBits-1:0], rad_ff[RAD_BITS-1 -: 2]};
      trial   = {root_ff, 2'b01};
      take    = (rem_sh >= trial);
      rem_in  = take ? (rem_sh - trial) : rem_sh;
      root_in = {root_ff[RootBits-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CntBits'(RootBits - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: rtl/core/wrench_to_motor_pulse_allocator.sv
// Top level of the wrench-to-motor pulse allocator for an eight-rotor vehicle.
// Uses wmpa_pkg and the iterative square root unit wmpa_isqrt.
//
// Each accepted word replaces the force (opcode 0) or torque (opcode 1) setpoint
// and yields one word of eight pulse widths. Setpoints live in a six-entry
// synchronous memory; a setpoint never written counts as zero. Per motor, six
// products go through one shared multiply-accumulate pipe, then a bit-serial
// square root with its load and handoff, a gain multiply and a saturate step.
// The next word is taken once the previous result has moved into the output
// register.
module wrench_to_motor_pulse_allocator #(
   parameter int SETPOINT_BITS = 16,
   parameter int COEF_BITS     = 18
) (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    csr_wr_en,
   input  wmpa_pkg::csr_index_type                 csr_index,
   input  logic [wmpa_pkg::CsrDataBits-1:0]        csr_wdata,

   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  wmpa_pkg::op_type                        req_opcode,
   input  logic signed [SETPOINT_BITS-1:0]         req_set_x,
   input  logic signed [SETPOINT_BITS-1:0]         req_set_y,
   input  logic signed [SETPOINT_BITS-1:0]         req_set_z,

   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [wmpa_pkg::PulseBits-1:0]          rsp_motor1_pulse,
   output logic [wmpa_pkg::PulseBits-1:0]          rsp_motor2_pulse,
   output logic [wmpa_pkg::PulseBits-1:0]          rsp_motor3_pulse,
   output logic [wmpa_pkg::PulseBits-1:0]          rsp_motor4_pulse,
   output logic [wmpa_pkg::PulseBits-1:0]          rsp_motor5_pulse,
   output logic [wmpa_pkg::PulseBits-1:0]          rsp_motor6_pulse,
   output logic [wmpa_pkg::PulseBits-1:0]          rsp_motor7_pulse,
   output logic [wmpa_pkg::PulseBits-1:0]          rsp_motor8_pulse
);

   import wmpa_pkg::*;

   localparam int SP        = SETPOINT_BITS;
   localparam int CB        = COEF_BITS;
   localparam int ProdBits  = SP + CB;
   localparam int AccBits   = SP + CB + 1;
   localparam int CoefFrac  = CB - CoefIntBits;
   localparam int FmagBits  = SP + 2;
   localparam int RadBits   = FmagBits + (FmagBits % 2);
   localparam int RootBits  = RadBits / 2;
   localparam int GrBits    = GainBits + RootBits;
   localparam int OffBits   = GrBits - RootGainFrac;
   localparam int PBits     = ((OffBits > PulseBits) ? OffBits : PulseBits) + 2;
   localparam int CoefShl   = (CB >= CoefRomBits) ? (CB - CoefRomBits) : 0;
   localparam int CoefShr   = (CB <  CoefRomBits) ? (CoefRomBits - CB) : 0;
   localparam logic [2:0] TorqueBase = 3'(AxisCount);
   localparam logic [2:0] LastTerm   = 3'(WrenchCount - 1);
   localparam logic [2:0] TermCount  = 3'(WrenchCount);
   localparam logic [2:0] LastMotor  = 3'(MotorCount - 1);
   localparam logic [1:0] LastAxis   = 2'(AxisCount - 1);

   function automatic logic signed [CB-1:0] coef_scale(
      input logic signed [CoefRomBits-1:0] c
   );
      logic [CoefRomBits-1:0]    mag;
      logic [CB+CoefRomBits-1:0] wide;
      logic [CB-1:0]             m;
      mag  = c[CoefRomBits-1] ? CoefRomBits'(-c) : CoefRomBits'(c);
      wide = ({{CB{1'b0}}, mag} << CoefShl) >> CoefShr;
      m    = wide[CB-1:0];
      return c[CoefRomBits-1] ? -$signed(m) : $signed(m);
   endfunction

   // configuration
   logic [PulseBits-1:0] center_ff, min_ff, max_ff;
   logic [GainBits-1:0]  gain_ff;

   // control
   state_type            state_ff, state_in;
   logic [1:0]           wr_idx_ff;
   logic [2:0]           mac_cnt_ff;
   logic [2:0]           motor_ff;
   logic                 force_seen_ff, torque_seen_ff;
   logic                 rd_v_ff, rd_last_ff, mul_v_ff, mul_last_ff;
   logic                 rsp_valid_ff;

   // strobes
   logic                 accept;
   logic                 mem_we;
   logic                 issue_en;
   logic                 acc_clr;
   logic                 sqrt_start;
   logic                 scale_en;
   logic                 apply_en;
   logic                 load_out;

   // payload
   op_type               op_ff;
   logic [SP-1:0]        x_ff, y_ff, z_ff;
   logic [SP-1:0]        sp_mem [WrenchCount];
   logic [SP-1:0]        rd_data_ff;
   logic                 zero_ff;
   logic signed [CB-1:0] coef_ff;
   logic signed [ProdBits-1:0] prod_ff;
   logic signed [AccBits-1:0]  acc_ff;
   logic                 neg_ff;
   logic [OffBits-1:0]   offset_ff;
   logic [PulseBits-1:0] pulse_ff [MotorCount];
   logic [PulseBits-1:0] rsp_pulse_ff [MotorCount];

   logic [2:0]           wr_addr;
   logic [SP-1:0]        wr_data;
   logic signed [SP-1:0] wrench_op;
   logic signed [ProdBits-1:0] prod_in;
   logic signed [AccBits-1:0]  acc_q;
   logic signed [AccBits-1:0]  fmag;
   logic [RadBits-1:0]   radicand;
   logic                 sqrt_done;
   logic [RootBits-1:0]  root;
   logic [GrBits-1:0]    gr_prod;
   logic signed [PBits-1:0] pulse_raw, pulse_lo, pulse_sat;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_WRITE;
         ST_WRITE: if (wr_idx_ff == LastAxis) state_in = ST_MAC;
         ST_MAC:   if (mul_v_ff && mul_last_ff) state_in = ST_NORM;
         ST_NORM:  state_in = ST_ROOT;
         ST_ROOT:  if (sqrt_done) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_APPLY;
         ST_APPLY: state_in = (motor_ff == LastMotor) ? ST_DONE : ST_MAC;
         ST_DONE:  if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // strobes
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      mem_we     = (state_ff == ST_WRITE);
      issue_en   = (state_ff == ST_MAC) && (mac_cnt_ff != TermCount);
      acc_clr    = (state_ff == ST_WRITE) || (state_ff == ST_NORM);
      sqrt_start = (state_ff == ST_NORM);
      scale_en   = (state_ff == ST_SCALE);
      apply_en   = (state_ff == ST_APPLY);
      load_out   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         wr_idx_ff      <= '0;
         mac_cnt_ff     <= '0;
         motor_ff       <= '0;
         force_seen_ff  <= 1'b0;
         torque_seen_ff <= 1'b0;
         rd_v_ff        <= 1'b0;
         rd_last_ff     <= 1'b0;
         mul_v_ff       <= 1'b0;
         mul_last_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         center_ff      <= PulseCenterReset;
         min_ff         <= PulseMinReset;
         max_ff         <= PulseMaxReset;
         gain_ff        <= ThrustGainReset;
      end else begin
         state_ff    <= state_in;
         rd_v_ff     <= issue_en;
         rd_last_ff  <= issue_en && (mac_cnt_ff == LastTerm);
         mul_v_ff    <= rd_v_ff;
         mul_last_ff <= rd_v_ff && rd_last_ff;
         if (accept) begin
            wr_idx_ff <= '0;
            motor_ff  <= '0;
            if (req_opcode == OP_TORQUE) begin
               torque_seen_ff <= 1'b1;
            end else begin
               force_seen_ff <= 1'b1;
            end
         end
         if (mem_we) wr_idx_ff <= wr_idx_ff + 1'b1;
         if (issue_en) begin
            mac_cnt_ff <= mac_cnt_ff + 1'b1;
         end else if (acc_clr) begin
            mac_cnt_ff <= '0;
         end
         if (apply_en) motor_ff <= motor_ff + 1'b1;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_PULSE_CENTER: center_ff <= csr_wdata[PulseBits-1:0];
               CSR_PULSE_MIN:    min_ff    <= csr_wdata[PulseBits-1:0];
               CSR_PULSE_MAX:    max_ff    <= csr_wdata[PulseBits-1:0];
               CSR_THRUST_GAIN:  gain_ff   <= csr_wdata[GainBits-1:0];
               default:          ;
            endcase
         end
      end
   end

   // setpoint memory: writes finish before the multiply pass reads
   always_comb begin
      wr_addr = (op_ff == OP_TORQUE) ? (3'(wr_idx_ff) + TorqueBase) : 3'(wr_idx_ff);
      unique case (wr_idx_ff)
         2'd0:    wr_data = x_ff;
         2'd1:    wr_data = y_ff;
         default: wr_data = z_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) sp_mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (issue_en) rd_data_ff <= sp_mem[mac_cnt_ff];
   end

   // datapath
   always_comb begin
      wrench_op = zero_ff ? '0 : $signed(rd_data_ff);
      prod_in   = coef_ff * wrench_op;
      acc_q     = acc_ff >>> CoefFrac;
      fmag      = acc_ff[AccBits-1] ? -acc_q : acc_q;
      radicand  = RadBits'(fmag);
      gr_prod   = GrBits'(gain_ff) * GrBits'(root);
      pulse_raw = neg_ff ? ($signed(PBits'(center_ff)) - $signed(PBits'(offset_ff)))
                         : ($signed(PBits'(center_ff)) + $signed(PBits'(offset_ff)));
      pulse_lo  = (pulse_raw < $signed(PBits'(min_ff))) ? $signed(PBits'(min_ff)) : pulse_raw;
      pulse_sat = (pulse_lo > $signed(PBits'(max_ff))) ? $signed(PBits'(max_ff)) : pulse_lo;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_opcode;
         x_ff  <= req_set_x;
         y_ff  <= req_set_y;
         z_ff  <= req_set_z;
      end
      if (issue_en) begin
         coef_ff <= coef_scale(ALLOC_ROM[motor_ff][mac_cnt_ff]);
         zero_ff <= (mac_cnt_ff < TorqueBase) ? !force_seen_ff : !torque_seen_ff;
      end
      if (rd_v_ff) prod_ff <= prod_in;
      if (acc_clr) begin
         acc_ff <= '0;
      end else if (mul_v_ff) begin
         acc_ff <= acc_ff + AccBits'(prod_ff);
      end
      if (sqrt_start) neg_ff <= acc_ff[AccBits-1];
      if (scale_en) offset_ff <= gr_prod[GrBits-1:RootGainFrac];
      if (apply_en) pulse_ff[motor_ff] <= pulse_sat[PulseBits-1:0];
      if (load_out) rsp_pulse_ff <= pulse_ff;
   end

   wmpa_isqrt #(
      .RAD_BITS (RadBits)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (root)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_motor1_pulse = rsp_pulse_ff[0];
   assign rsp_motor2_pulse = rsp_pulse_ff[1];
   assign rsp_motor3_pulse = rsp_pulse_ff[2];
   assign rsp_motor4_pulse = rsp_pulse_ff[3];
   assign rsp_motor5_pulse = rsp_pulse_ff[4];
   assign rsp_motor6_pulse = rsp_pulse_ff[5];
   assign rsp_motor7_pulse = rsp_pulse_ff[6];
   assign rsp_motor8_pulse = rsp_pulse_ff[7];

endmodule

// File: sim/wrench_to_motor_pulse_allocator_tb.sv
// Testbench for the wrench-to-motor pulse allocator: setpoint words in, pulse words out.
// A scoreboard class predicts the eight pulses per word and checks them in order.
// Depends on wmpa_pkg and wrench_to_motor_pulse_allocator.
`timescale 1ns / 100ps

module wrench_to_motor_pulse_allocator_tb;
   import wmpa_pkg::*;

   localparam int SpBits      = 16;
   localparam int CycleLimit  = 1500000;
   localparam int DrainCycles = 400;
   localparam int LongHold    = 700;
   localparam int IdlePercent = 38;
   localparam int PrintCap    = 40;
   localparam int CoefA       = 9691;
   localparam int CoefB       = 2597;
   localparam int CoefC       = 7094;

   typedef logic [MotorCount-1:0][PulseBits-1:0] pulse_set_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_wr_en;
   csr_index_type            csr_index;
   logic [CsrDataBits-1:0]   csr_wdata;
   logic                     req_valid;
   logic                     req_stall;
   op_type                   req_opcode;
   logic signed [SpBits-1:0] req_set_x;
   logic signed [SpBits-1:0] req_set_y;
   logic signed [SpBits-1:0] req_set_z;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [PulseBits-1:0]     rsp_motor1_pulse;
   logic [PulseBits-1:0]     rsp_motor2_pulse;
   logic [PulseBits-1:0]     rsp_motor3_pulse;
   logic [PulseBits-1:0]     rsp_motor4_pulse;
   logic [PulseBits-1:0]     rsp_motor5_pulse;
   logic [PulseBits-1:0]     rsp_motor6_pulse;
   logic [PulseBits-1:0]     rsp_motor7_pulse;
   logic [PulseBits-1:0]     rsp_motor8_pulse;

   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   int hold_requests  = 0;
   int holds_served   = 0;
   int hold_left      = 0;
   int settings_used  = 1;

   class pulse_ledger;
      int                 coef_tab[48];
      logic signed [15:0] lin_hold[3];
      logic signed [15:0] rot_hold[3];
      bit                 force_seen;
      bit                 torque_seen;
      int                 center;
      int                 floor_us;
      int                 ceiling_us;
      int                 gain;
      pulse_set_type      awaited_pulses[$];
      int                 mismatches;
      int                 words_in;
      int                 words_out;

      function new();
         coef_tab = '{
            -CoefA,  CoefB,  CoefC,  CoefB, -CoefA,  CoefC,
             CoefB,  CoefA, -CoefC, -CoefA, -CoefB, -CoefC,
            -CoefB, -CoefA, -CoefC,  CoefA,  CoefB, -CoefC,
             CoefA, -CoefB,  CoefC, -CoefB,  CoefA,  CoefC,
             CoefA, -CoefB,  CoefC,  CoefB, -CoefA, -CoefC,
            -CoefB, -CoefA, -CoefC, -CoefA, -CoefB,  CoefC,
             CoefB,  CoefA, -CoefC,  CoefA,  CoefB,  CoefC,
            -CoefA,  CoefB,  CoefC, -CoefB,  CoefA, -CoefC};
         force_seen  = 1'b0;
         torque_seen = 1'b0;
         center      = 1500;
         floor_us    = 1000;
         ceiling_us  = 2000;
         gain        = 65037;
         mismatches  = 0;
         words_in    = 0;
         words_out   = 0;
      endfunction

      function void set_csr(csr_index_type idx, logic [15:0] data);
         case (idx)
            CSR_PULSE_CENTER: center     = int'(data[11:0]);
            CSR_PULSE_MIN:    floor_us   = int'(data[11:0]);
            CSR_PULSE_MAX:    ceiling_us = int'(data[11:0]);
            CSR_THRUST_GAIN:  gain       = int'(data);
            default: ;
         endcase
      endfunction

      function longint root_floor(longint v);
         longint r;
         longint t;
         r = 0;
         for (int k = 16; k >= 0; k--) begin
            t = r | (longint'(1) << k);
            if (t * t <= v)
               r = t;
         end
         return r;
      endfunction

      function pulse_set_type predict_pulses();
         longint        wrench[6];
         longint        acc;
         longint        force_mag;
         longint        offset;
         longint        pulse;
         pulse_set_type res;
         for (int j = 0; j < 3; j++) begin
            wrench[j]     = force_seen  ? longint'(lin_hold[j]) : 0;
            wrench[3 + j] = torque_seen ? longint'(rot_hold[j]) : 0;
         end
         for (int m = 0; m < MotorCount; m++) begin
            acc = 0;
            for (int j = 0; j < 6; j++)
               acc += longint'(coef_tab[m * 6 + j]) * wrench[j];
            // floor toward minus infinity, then take the magnitude
            force_mag = acc >>> 15;
            if (force_mag < 0)
               force_mag = -force_mag;
            offset = (longint'(gain) * root_floor(force_mag)) >>> 12;
            pulse  = (acc < 0) ? longint'(center) - offset : longint'(center) + offset;
            if (pulse < floor_us)
               pulse = floor_us;
            if (pulse > ceiling_us)
               pulse = ceiling_us;
            res[m] = pulse[11:0];
         end
         return res;
      endfunction

      function void note_word(op_type op, logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
         if (op == OP_FORCE) begin
            lin_hold   = '{x, y, z};
            force_seen = 1'b1;
         end else begin
            rot_hold    = '{x, y, z};
            torque_seen = 1'b1;
         end
         awaited_pulses.push_back(predict_pulses());
         words_in++;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= PrintCap)
            $display("%0t MISMATCH %s", $time, msg);
      endtask

      task check_word(pulse_set_type got);
         pulse_set_type want;
         if (awaited_pulses.size() == 0) begin
            report_mismatch($sformatf("pulse word %0d arrived with none pending", words_out));
            words_out++;
            return;
         end
         want = awaited_pulses.pop_front();
         for (int m = 0; m < MotorCount; m++)
            if (got[m] !== want[m])
               report_mismatch($sformatf("word %0d motor%0d_pulse got %0d want %0d",
                                         words_out, m + 1, got[m], want[m]));
         words_out++;
      endtask

      function int pending();
         return awaited_pulses.size();
      endfunction
   endclass

   pulse_ledger ledger;

   wrench_to_motor_pulse_allocator #(
      .SETPOINT_BITS(SpBits),
      .COEF_BITS    (18)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_set_x       (req_set_x),
      .req_set_y       (req_set_y),
      .req_set_z       (req_set_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_motor1_pulse(rsp_motor1_pulse),
      .rsp_motor2_pulse(rsp_motor2_pulse),
      .rsp_motor3_pulse(rsp_motor3_pulse),
      .rsp_motor4_pulse(rsp_motor4_pulse),
      .rsp_motor5_pulse(rsp_motor5_pulse),
      .rsp_motor6_pulse(rsp_motor6_pulse),
      .rsp_motor7_pulse(rsp_motor7_pulse),
      .rsp_motor8_pulse(rsp_motor8_pulse)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
         ledger.check_word({rsp_motor8_pulse, rsp_motor7_pulse, rsp_motor6_pulse,
                            rsp_motor5_pulse, rsp_motor4_pulse, rsp_motor3_pulse,
                            rsp_motor2_pulse, rsp_motor1_pulse});
      if (hold_requests != holds_served) begin
         holds_served++;
         hold_left = LongHold;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= receiver_idles && ($urandom_range(99) < IdlePercent);
      end
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("Timeout after %0d cycles", CycleLimit);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_word(op_type op, logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
      while (sender_idles && $urandom_range(99) < IdlePercent) begin
         req_valid  <= 1'b0;
         req_opcode <= op_type'($urandom_range(1));
         req_set_x  <= 16'($urandom);
         req_set_y  <= 16'($urandom);
         req_set_z  <= 16'($urandom);
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_set_x  <= x;
      req_set_y  <= y;
      req_set_z  <= z;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      ledger.note_word(op, x, y, z);
   endtask

   function automatic logic signed [15:0] pick_setpoint();
      logic signed [15:0] v;
      case ($urandom_range(2))
         0:       v = 16'($urandom);
         1:       v = 16'($urandom_range(8191) - 4096);
         default: v = 16'($urandom_range(600) - 300);
      endcase
      return v;
   endfunction

   task automatic send_random(int count);
      for (int i = 0; i < count; i++)
         send_word(op_type'($urandom_range(1)), pick_setpoint(), pick_setpoint(),
                   pick_setpoint());
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      do @(posedge clock); while (ledger.pending() != 0);
   endtask

   task automatic write_reg(csr_index_type idx, int value);
      logic [15:0] data;
      data = 16'($urandom);
      if (idx == CSR_THRUST_GAIN)
         data = value[15:0];
      else
         data[11:0] = value[11:0];
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      ledger.set_csr(idx, data);
      @(posedge clock);
   endtask

   task automatic apply_setting(int center, int floor_us, int ceiling_us, int gain);
      drain_words();
      write_reg(CSR_PULSE_CENTER, center);
      write_reg(CSR_PULSE_MIN, floor_us);
      write_reg(CSR_PULSE_MAX, ceiling_us);
      write_reg(CSR_THRUST_GAIN, gain);
      csr_wr_en <= 1'b0;
      csr_wdata <= CsrDataBits'($urandom);
      settings_used++;
   endtask

   initial begin
      ledger     = new();
      reset      <= 1'b1;
      csr_wr_en  <= 1'b0;
      csr_index  <= CSR_PULSE_CENTER;
      csr_wdata  <= '0;
      req_valid  <= 1'b0;
      req_opcode <= OP_FORCE;
      req_set_x  <= '0;
      req_set_y  <= '0;
      req_set_z  <= '0;
      rsp_stall  <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings; force unseen first, then extremes and rounding
      send_word(OP_TORQUE, 16'sd1000, -16'sd500, 16'sd300);
      send_word(OP_FORCE, 16'sd0, 16'sd0, 16'sd0);
      send_word(OP_TORQUE, 16'sd0, 16'sd0, 16'sd0);
      send_word(OP_FORCE, 16'sd1, 16'sd0, 16'sd0);
      send_word(OP_FORCE, -16'sd1, -16'sd1, -16'sd1);
      send_word(OP_FORCE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_word(OP_FORCE, 16'sh8000, 16'sh8000, 16'sh8000);
      send_word(OP_TORQUE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_word(OP_TORQUE, 16'sh8000, 16'sh8000, 16'sh8000);
      send_word(OP_FORCE, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      send_word(OP_TORQUE, 16'sh8000, 16'sh7FFF, 16'sh8000);
      send_word(OP_FORCE, 16'sh5555, 16'shAAAA, 16'sh5555);
      send_word(OP_TORQUE, 16'shAAAA, 16'sh5555, 16'shAAAA);
      send_word(OP_FORCE, 16'sd256, -16'sd256, 16'sd512);
      send_word(OP_TORQUE, 16'sd64, 16'sd128, -16'sd64);

      send_random(60);
      // hold the receiver off while words keep coming
      hold_requests++;
      send_random(30);
      drain_words();
      send_random(40);

      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      apply_setting(2048, 0, 4095, 65535);
      send_random(120);
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;

      apply_setting(4095, 0, 4095, 65535);
      send_random(100);
      apply_setting(0, 0, 4095, 65535);
      send_random(100);
      apply_setting(1500, 3000, 1000, 65037);
      send_random(100);
      apply_setting(2000, 0, 4095, 0);
      send_random(100);
      for (int p = 0; p < 4; p++) begin
         apply_setting($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                       $urandom_range(65535));
         send_random(100);
      end
      apply_setting(1500, 1000, 2000, 65037);
      send_random(100);

      drain_words();
      repeat (DrainCycles) @(posedge clock);
      $display("Checked %0d pulse words from %0d setpoint words under %0d register settings",
               ledger.words_out, ledger.words_in, settings_used);
      $display("Included saturation both ways, inverted limits, zero gain and long stalls");
      if (ledger.mismatches == 0 && ledger.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d words still pending", ledger.mismatches,
                  ledger.pending());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/wmpa_pkg.sv
rtl/core/wmpa_isqrt.sv
rtl/core/wrench_to_motor_pulse_allocator.sv
sim/wrench_to_motor_pulse_allocator_tb.sv
